/* sv/mzr_pkg.sv */
// Shared types and constants for the mzran13 random generator core.
// Used by the front end, the work queue, the back end and the top level.
`timescale 1ns / 1ps

package mzr_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned BOUND_W = 31;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [WORD_W-1:0] LCG_MUL      = 32'd69069;
   localparam logic [WORD_W-1:0] LCG_ADD      = 32'd1013904243;
   localparam logic [WORD_W-1:0] BORROW_EXTRA = 32'd18;

   localparam logic [WORD_W-1:0] SEED_OLDEST_RST = 32'd99;
   localparam logic [WORD_W-1:0] SEED_MIDDLE_RST = 32'd199;
   localparam logic [WORD_W-1:0] SEED_NEWEST_RST = 32'd13;
   localparam logic [WORD_W-1:0] SEED_CONG_RST   = 32'd77;

   // queue between front and back end
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = 2;
   localparam int unsigned QCNT_W = 3;

   // division unit
   localparam int unsigned DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

   typedef enum logic [KIND_W-1:0] {
      REQ_RAW     = 2'd0,
      REQ_BOUNDED = 2'd1,
      REQ_RESEED  = 2'd2
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEED_OLDEST = 2'd0,
      CSR_SEED_MIDDLE = 2'd1,
      CSR_SEED_NEWEST = 2'd2,
      CSR_SEED_CONG   = 2'd3
   } csr_index_type;

   // one classified job handed from front to back
   typedef struct packed {
      logic                reduce;
      logic                error;
      logic [BOUND_W-1:0]  bound;
      logic [WORD_W-1:0]   data;
   } mzr_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } mzr_qstat_type;

endpackage

/* sv/mzran13_random_generator_core.sv */
// mzran13 generator: raw draw, zero-bound draw, reseed and unused request give a
// valid result once the job has passed the queue and the output register (the queue
// pop and output load happen in the same cycle). Bounded draw: queue pop, 32 remainder
// steps, then output load; the single bit-serial remainder unit takes one bounded draw
// at a time, and other items flow at one per cycle only while it is idle and the output
// is not held. Synchronous active-high reset restores seeds 99/199/13/77, borrow 1,
// empties the queue and drops any pending result.
`timescale 1ns / 1ps

module mzran13_random_generator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [mzr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mzr_pkg::WORD_W-1:0]    csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,  // [30:0] bound, [31] zero
   input  logic [mzr_pkg::KIND_W-1:0]    req_tuser,  // [1:0] req_type
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,  // [31:0] value
   output logic                          rsp_tuser   // [0] error
);
   import mzr_pkg::*;

   mzr_job_type   push_job, head_job;
   mzr_qstat_type q_stat;
   logic          push, pop;

   mzr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_bound  (req_tdata[BOUND_W-1:0]),
      .req_kind   (req_tuser),
      .q_stat     (q_stat),
      .q_push     (push),
      .q_job      (push_job)
   );

   mzr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   mzr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_tdata),
      .rsp_error  (rsp_tuser)
   );

endmodule

/* sv/mzr_front.sv */
// Front end: seed registers, generator state and request classification.
// Depends on mzr_pkg; pushes one job per accepted request into mzr_queue.
`timescale 1ns / 1ps

module mzr_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [mzr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mzr_pkg::WORD_W-1:0] csr_wdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [mzr_pkg::BOUND_W-1:0] req_bound,
   input  logic [mzr_pkg::KIND_W-1:0] req_kind,
   input  mzr_pkg::mzr_qstat_type    q_stat,
   output logic                      q_push,
   output mzr_pkg::mzr_job_type      q_job
);
   import mzr_pkg::*;

   logic [WORD_W-1:0] seed_old_ff, seed_mid_ff, seed_new_ff, seed_cong_ff;
   logic [WORD_W-1:0] lag_old_ff, lag_mid_ff, lag_new_ff, cong_ff;
   logic              borrow_ff;

   logic [WORD_W-1:0] lag_old_in, lag_mid_in, lag_new_in, cong_in;
   logic              borrow_in;

   logic [WORD_W-1:0] sub, diff, s_next, cong_next, draw;
   logic              borrow_next;
   logic              take;

   assign req_tready = !q_stat.full;
   assign take       = req_tvalid && req_tready;

   // subtract-with-borrow step and congruential step
   always_comb begin
      sub  = lag_old_ff + WORD_W'(borrow_ff);
      diff = lag_mid_ff - sub;
      if (lag_mid_ff > sub) begin
         s_next      = diff;
         borrow_next = 1'b0;
      end else begin
         s_next      = diff - BORROW_EXTRA;
         borrow_next = 1'b1;
      end
      cong_next = WORD_W'(cong_ff * LCG_MUL) + LCG_ADD;
      draw      = s_next + cong_next;
   end

   always_comb begin
      lag_old_in = lag_old_ff;
      lag_mid_in = lag_mid_ff;
      lag_new_in = lag_new_ff;
      cong_in    = cong_ff;
      borrow_in  = borrow_ff;
      q_job      = '0;
      case (req_kind_type'(req_kind))
         REQ_RAW: begin
            q_job.data = draw;
         end
         REQ_BOUNDED: begin
            if (req_bound == '0) begin
               q_job.error = 1'b1;
            end else begin
               q_job.reduce = 1'b1;
               q_job.bound  = req_bound;
               q_job.data   = draw;
            end
         end
         REQ_RESEED: begin
            lag_old_in = seed_old_ff;
            lag_mid_in = seed_mid_ff;
            lag_new_in = seed_new_ff;
            cong_in    = seed_cong_ff;
            borrow_in  = 1'b1;
         end
         default: begin
         end
      endcase
      // advance only on a real draw
      if (req_kind_type'(req_kind) == REQ_RAW ||
          (req_kind_type'(req_kind) == REQ_BOUNDED && req_bound != '0)) begin
         lag_old_in = lag_mid_ff;
         lag_mid_in = lag_new_ff;
         lag_new_in = s_next;
         cong_in    = cong_next;
         borrow_in  = borrow_next;
      end
   end

   assign q_push = take;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_old_ff  <= SEED_OLDEST_RST;
         seed_mid_ff  <= SEED_MIDDLE_RST;
         seed_new_ff  <= SEED_NEWEST_RST;
         seed_cong_ff <= SEED_CONG_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SEED_OLDEST: seed_old_ff  <= csr_wdata;
            CSR_SEED_MIDDLE: seed_mid_ff  <= csr_wdata;
            CSR_SEED_NEWEST: seed_new_ff  <= csr_wdata;
            CSR_SEED_CONG:   seed_cong_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lag_old_ff <= SEED_OLDEST_RST;
         lag_mid_ff <= SEED_MIDDLE_RST;
         lag_new_ff <= SEED_NEWEST_RST;
         cong_ff    <= SEED_CONG_RST;
         borrow_ff  <= 1'b1;
      end else if (take) begin
         lag_old_ff <= lag_old_in;
         lag_mid_ff <= lag_mid_in;
         lag_new_ff <= lag_new_in;
         cong_ff    <= cong_in;
         borrow_ff  <= borrow_in;
      end
   end

endmodule

/* sv/mzr_queue.sv */
// Short job queue between the front end and the back end.
// Depends on mzr_pkg for the job type and depth constants.
`timescale 1ns / 1ps

module mzr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mzr_pkg::mzr_job_type   push_job,
   input  logic                   pop,
   output mzr_pkg::mzr_job_type   head_job,
   output mzr_pkg::mzr_qstat_type stat
);
   import mzr_pkg::*;

   mzr_job_type         slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   assign stat.full  = (count_ff == QCNT_W'(QDEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !stat.full || pop)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty)
      else $error("queue pop while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count out of range");

endmodule

/* sv/mzr_back.sv */
// Back end: bit-serial remainder unit and the result output register.
// Depends on mzr_pkg; pops jobs from mzr_queue.
`timescale 1ns / 1ps

module mzr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  mzr_pkg::mzr_job_type       head_job,
   input  mzr_pkg::mzr_qstat_type     q_stat,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [mzr_pkg::WORD_W-1:0] rsp_value,
   output logic                       rsp_error
);
   import mzr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [WORD_W-1:0]    dvd_ff, dvd_in;
   logic [BOUND_W-1:0]   rem_ff, rem_in;
   logic [BOUND_W-1:0]   bnd_ff, bnd_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 out_vld_ff, out_vld_in;
   logic [WORD_W-1:0]    out_val_ff, out_val_in;
   logic                 out_err_ff, out_err_in;

   logic                 out_free;
   logic [WORD_W-1:0]    trial;
   logic [WORD_W-1:0]    trial_diff;

   assign out_free   = !out_vld_ff || rsp_tready;
   assign trial      = {rem_ff, dvd_ff[WORD_W-1]};
   assign trial_diff = trial - {1'b0, bnd_ff};

   always_comb begin
      state_in   = state_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      bnd_in     = bnd_ff;
      cnt_in     = cnt_ff;
      out_vld_in = rsp_tready ? 1'b0 : out_vld_ff;
      out_val_in = out_val_ff;
      out_err_in = out_err_ff;
      pop        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               if (head_job.reduce) begin
                  pop      = 1'b1;
                  dvd_in   = head_job.data;
                  bnd_in   = head_job.bound;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end else if (out_free) begin
                  pop        = 1'b1;
                  out_vld_in = 1'b1;
                  out_val_in = head_job.data;
                  out_err_in = head_job.error;
               end
            end
         end
         ST_DIV: begin
            // one restoring step per cycle, quotient bits are dropped
            if (!trial_diff[WORD_W-1] && trial >= {1'b0, bnd_ff}) begin
               rem_in = trial_diff[BOUND_W-1:0];
            end else begin
               rem_in = trial[BOUND_W-1:0];
            end
            dvd_in = {dvd_ff[WORD_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_val_in = {1'b0, rem_ff};
               out_err_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      bnd_ff     <= bnd_in;
      cnt_ff     <= cnt_in;
      out_val_ff <= out_val_in;
      out_err_ff <= out_err_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_value  = out_val_ff;
   assign rsp_error  = out_err_ff;

   a_rem_below_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> rem_ff < bnd_ff)
      else $error("partial remainder not below bound");

   a_bound_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> bnd_ff != '0)
      else $error("division started with zero bound");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == ST_IDLE)
      else $error("job taken while division busy");

   a_error_zero_value: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_err_ff |-> out_val_ff == '0)
      else $error("error result carries nonzero value");

   a_done_after_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && cnt_ff == DIV_LAST |=> state_ff == ST_DONE)
      else $error("division did not finish after last step");

endmodule

/* tb/sv/mzran13_draw_checker.sv */
// Checker for the mzran13 generator core: watches the seed writes and both stream
// channels, predicts each draw and compares it with the result transfers in order.
// Depends on mzr_pkg for widths, request kinds, seed indexes and constants.
`timescale 1ns / 1ps

module mzran13_draw_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [mzr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mzr_pkg::WORD_W-1:0]    csr_wdata,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [31:0]                   req_tdata,  // [30:0] bound, [31] zero
   input  logic [mzr_pkg::KIND_W-1:0]    req_tuser,  // [1:0] req_type
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [31:0]                   rsp_tdata,  // [31:0] value
   input  logic                          rsp_tuser,  // [0] error
   output int                            mismatch_count,
   output int                            pending_count
);
   import mzr_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              error;
   } draw_result_type;

   draw_result_type pending_draws[$];
   int              fail_tally = 0;

   logic [WORD_W-1:0] seed_old, seed_mid, seed_new, seed_cong;
   logic [WORD_W-1:0] lag_old, lag_mid, lag_new, cong_word;
   logic              borrow_bit;

   // subtract-with-borrow step on the lag plus one congruential step
   task automatic advance_lag(output logic [WORD_W-1:0] draw);
      logic [WORD_W-1:0] subtrahend;
      logic [WORD_W-1:0] diff;
      subtrahend = lag_old + {{(WORD_W-1){1'b0}}, borrow_bit};
      if (lag_mid > subtrahend) begin
         diff       = lag_mid - subtrahend;
         borrow_bit = 1'b0;
      end else begin
         diff       = lag_mid - subtrahend - BORROW_EXTRA;
         borrow_bit = 1'b1;
      end
      lag_old   = lag_mid;
      lag_mid   = lag_new;
      lag_new   = diff;
      cong_word = cong_word * LCG_MUL + LCG_ADD;
      draw      = lag_new + cong_word;
   endtask

   task automatic predict_draw(input logic [KIND_W-1:0] kind, input logic [BOUND_W-1:0] bnd,
                               output draw_result_type res);
      logic [WORD_W-1:0] draw;
      res = '0;
      case (kind)
         REQ_RAW: begin
            advance_lag(draw);
            res.value = draw;
         end
         REQ_BOUNDED: begin
            // zero bound flags an error and leaves the generator alone
            if (bnd == '0) begin
               res.error = 1'b1;
            end else begin
               advance_lag(draw);
               res.value = draw % {1'b0, bnd};
            end
         end
         REQ_RESEED: begin
            lag_old    = seed_old;
            lag_mid    = seed_mid;
            lag_new    = seed_new;
            cong_word  = seed_cong;
            borrow_bit = 1'b1;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      draw_result_type want;
      draw_result_type got;
      if (reset) begin
         seed_old   = SEED_OLDEST_RST;
         seed_mid   = SEED_MIDDLE_RST;
         seed_new   = SEED_NEWEST_RST;
         seed_cong  = SEED_CONG_RST;
         lag_old    = SEED_OLDEST_RST;
         lag_mid    = SEED_MIDDLE_RST;
         lag_new    = SEED_NEWEST_RST;
         cong_word  = SEED_CONG_RST;
         borrow_bit = 1'b1;
         pending_draws.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SEED_OLDEST: seed_old  = csr_wdata;
               CSR_SEED_MIDDLE: seed_mid  = csr_wdata;
               CSR_SEED_NEWEST: seed_new  = csr_wdata;
               CSR_SEED_CONG:   seed_cong = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata;
            got.error = rsp_tuser;
            if (pending_draws.size() == 0) begin
               $error("unexpected result transfer: value %h error %b", got.value, got.error);
               fail_tally++;
            end else begin
               want = pending_draws.pop_front();
               if (got.value !== want.value) begin
                  $error("value: expected %h, actual %h", want.value, got.value);
                  fail_tally++;
               end
               if (got.error !== want.error) begin
                  $error("error: expected %b, actual %b", want.error, got.error);
                  fail_tally++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_draw(req_tuser, req_tdata[BOUND_W-1:0], want);
            pending_draws.push_back(want);
         end
      end
      mismatch_count <= fail_tally;
      pending_count  <= pending_draws.size();
   end

endmodule

/* tb/sv/mzran13_random_generator_core_tb.sv */
// Top of the mzran13 generator testbench: clock, reset, seed writes, request
// stimulus with random idling and a long result hold-off, and the final verdict.
// Depends on mzr_pkg, mzran13_random_generator_core and mzran13_draw_checker.
`timescale 1ns / 1ps

module mzran13_random_generator_core_tb;
   import mzr_pkg::*;

   localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_ITEMS   = 220;
   localparam int PHASES        = 5;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [WORD_W-1:0]    csr_wdata  = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata  = '0;  // [30:0] bound, [31] zero
   logic [KIND_W-1:0]    req_tuser  = '0;  // [1:0] req_type
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;        // [31:0] value
   logic                 rsp_tuser;        // [0] error

   int mismatch_count;
   int pending_count;
   int send_idle_pct = 25;
   int recv_idle_pct = 25;
   bit hold_trigger  = 1'b0;

   mzran13_random_generator_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   mzran13_draw_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // result side: random back-pressure, plus one long hold-off when asked
   initial begin : receiver
      int hold_left;
      bit hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_trigger && !hold_used) begin
            hold_left = HOLD_CYCLES;
            hold_used = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_req(input logic [KIND_W-1:0] kind, input logic [BOUND_W-1:0] bnd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, bnd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // drop valid and wait until every draw is back and the core is quiet
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_seeds(input logic [WORD_W-1:0] s_old, input logic [WORD_W-1:0] s_mid,
                             input logic [WORD_W-1:0] s_new, input logic [WORD_W-1:0] s_cong);
      csr_we    <= 1'b1;
      csr_index <= CSR_SEED_OLDEST;
      csr_wdata <= s_old;
      @(posedge clock);
      csr_index <= CSR_SEED_MIDDLE;
      csr_wdata <= s_mid;
      @(posedge clock);
      csr_index <= CSR_SEED_NEWEST;
      csr_wdata <= s_new;
      @(posedge clock);
      csr_index <= CSR_SEED_CONG;
      csr_wdata <= s_cong;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic send_random_item();
      int                 pick;
      int                 bound_pick;
      logic [BOUND_W-1:0] bnd;
      pick       = $urandom_range(99);
      bound_pick = $urandom_range(99);
      if (bound_pick < 6) begin
         bnd = '0;
      end else if (bound_pick < 12) begin
         bnd = '1;
      end else if (bound_pick < 40) begin
         bnd = BOUND_W'($urandom_range(255, 1));
      end else begin
         bnd = BOUND_W'($urandom());
      end
      if (pick < 45) begin
         send_req(REQ_RAW, bnd);
      end else if (pick < 87) begin
         send_req(REQ_BOUNDED, bnd);
      end else if (pick < 95) begin
         send_req(REQ_RESEED, bnd);
      end else begin
         send_req(REQ_UNUSED, bnd);
      end
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // draws from the reset state, bound extremes, zero bound, reseed from reset seeds
      send_req(REQ_RAW, '0);
      send_req(REQ_RAW, '1);
      send_req(REQ_BOUNDED, 31'd1);
      send_req(REQ_BOUNDED, '1);
      send_req(REQ_BOUNDED, '0);
      send_req(REQ_BOUNDED, 31'h2AAA_AAAA);
      send_req(REQ_BOUNDED, 31'h5555_5555);
      send_req(REQ_UNUSED, 31'd12345);
      send_req(REQ_RESEED, '0);
      send_req(REQ_RAW, '0);
      send_req(REQ_BOUNDED, 31'd3);
      send_req(REQ_BOUNDED, 31'h4000_0000);

      wait_drained();
      load_seeds('0, '0, '0, '0);
      send_req(REQ_RESEED, '0);
      send_req(REQ_RAW, '0);
      send_req(REQ_RAW, '0);
      send_req(REQ_BOUNDED, 31'd5);

      // all-ones seeds: the oldest word plus borrow wraps to zero
      wait_drained();
      load_seeds('1, '1, '1, '1);
      send_req(REQ_RESEED, '1);
      send_req(REQ_RAW, '1);
      send_req(REQ_RAW, '0);
      send_req(REQ_BOUNDED, '1);

      wait_drained();
      load_seeds('0, '1, 32'h1234_5678, '1);
      send_req(REQ_RESEED, '0);
      send_req(REQ_RAW, '0);
      send_req(REQ_BOUNDED, '0);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            2:       load_seeds('1, '0, '1, '0);
            3:       load_seeds(SEED_OLDEST_RST, SEED_MIDDLE_RST, SEED_NEWEST_RST, SEED_CONG_RST);
            default: load_seeds($urandom(), $urandom(), $urandom(), $urandom());
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off the result side while requests keep coming back to back
            if (phase == 1 && n == 20) begin
               hold_trigger  = 1'b1;
               send_idle_pct = 0;
            end
            if (phase == 1 && n == 80) send_idle_pct = 25;
            // long stretch with no idling on either side
            if (phase == 3 && n == 0) begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            if (phase == 3 && n == 150) begin
               send_idle_pct = 25;
               recv_idle_pct = 25;
            end
            send_random_item();
         end
      end

      wait_drained();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/mzr_pkg.sv
sv/mzr_front.sv
sv/mzr_queue.sv
sv/mzr_back.sv
sv/mzran13_random_generator_core.sv
tb/sv/mzran13_draw_checker.sv
tb/sv/mzran13_random_generator_core_tb.sv
